/* rtl/psr_pkg.sv */
// Package for the polyline segment resampler.
// Holds the shared constants, the sequencer state type and the unit command type.
// No dependencies.
package psr_pkg;

  localparam int unsigned CoordW    = 32;
  localparam int unsigned DeltaW    = 33;
  localparam int unsigned SumW      = 68;
  localparam int unsigned LenW      = 34;
  localparam int unsigned StepW     = 31;
  localparam int unsigned MaxSubdiv = 62;
  localparam int unsigned CntW      = 6;
  localparam int unsigned ProdW     = 40;
  localparam logic [31:0] StepReset = 32'd65536;
  localparam logic [0:0]  AddrStep  = 1'b0;

  typedef enum logic [3:0] {
    StIdle,
    StSquare,
    StSqrt,
    StDiv,
    StPoint,
    StQuot,
    StOut,
    StFinal
  } state_e;

  typedef struct packed {
    logic              start;
    logic [ProdW-1:0]  numer;
    logic [CntW-1:0]   denom;
  } div_req_t;

endpackage

/* rtl/psr_divider.sv */
// Shared restoring divider: one quotient bit per cycle, truncation toward zero.
// Computes numer / denom for unsigned magnitudes; depends on psr_pkg.
module psr_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  psr_pkg::div_req_t         req_i,
  output logic                      busy_o,
  output logic [psr_pkg::ProdW-1:0] quot_o
);

  logic [psr_pkg::ProdW-1:0] quot_q, quot_d;
  logic [psr_pkg::CntW:0]    rem_q, rem_d;
  logic [psr_pkg::CntW-1:0]  den_q, den_d;
  logic [5:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic [psr_pkg::CntW:0]    trial;

  assign trial = {rem_q[psr_pkg::CntW-1:0], quot_q[psr_pkg::ProdW-1]};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      quot_d = req_i.numer;
      rem_d  = '0;
      den_d  = req_i.denom;
      cnt_d  = 6'(psr_pkg::ProdW - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[psr_pkg::ProdW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d     = trial - {1'b0, den_q};
        quot_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

/* rtl/polyline_segment_resampler.sv */
// Top level of the polyline segment resampler.
// Depends on psr_pkg and psr_divider.
//
// Vertices enter on the point channel (valid/ready) and resampled points leave
// on the output channel (valid/ready). Step length is set through the APB port
// at address 0 and reads back there; pready is always high.
// A first vertex is stored and gives no transfer unless it is marked final.
// Each later vertex closes a segment: three squares are summed, the length is
// found by a 34-step bit-serial square root, and n = length / step by a 34-step
// restoring division, both on the sequencer's shift/subtract datapath. Every
// one of the n+1 points (n <= 62) then takes three 40-step divisions in the
// shared divider, one per axis, and passes the output state. A final vertex is
// then sent once more with boundary_end set.
// The block takes no vertex while it works on one; the point register holds
// while the receiver stalls, and the sequence resumes on the transfer. Reset
// clears the stored vertex flag, sets step_length to 65536 and idles the
// sequencer.
module polyline_segment_resampler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               point_valid_i,
  output logic               point_ready_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic               is_final_vertex_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               run_last_o,
  output logic               boundary_end_o
);

  localparam int unsigned DW = psr_pkg::DeltaW;
  localparam int unsigned SW = psr_pkg::SumW;
  localparam int unsigned LW = psr_pkg::LenW;
  localparam int unsigned PW = psr_pkg::ProdW;
  localparam int unsigned NW = psr_pkg::CntW;

  psr_pkg::state_e state_q, state_d;

  logic [psr_pkg::StepW-1:0] step_q;
  logic                      have_prev_q, have_prev_d;
  logic signed [31:0]        px_q, py_q, pz_q, cx_q, cy_q, cz_q;
  logic                      fin_q;
  logic signed [DW-1:0]      dl_q [3];
  logic [SW-1:0]             acc_q, acc_d;
  logic [LW-1:0]             root_q, root_d;
  logic [SW+1:0]             rem_q, rem_d;
  logic [SW-1:0]             sh_q, sh_d;
  logic [5:0]                cnt_q, cnt_d;
  logic [1:0]                ax_q, ax_d;
  logic [NW-1:0]             n_q, n_d, j_q, j_d;
  logic                      go_q, go_d;
  logic signed [31:0]        res_q [3];
  logic signed [31:0]        res_d [3];
  logic signed [31:0]        ox_q, oy_q, oz_q;
  logic                      orl_q, obe_q, ov_q, ov_d;
  logic                      load_out;

  logic [DW-1:0]             mag;
  logic [2*DW-1:0]           sq;
  logic [SW+1:0]             trial;
  logic [PW-1:0]             jmag;
  psr_pkg::div_req_t         dreq;
  logic                      dbusy;
  logic [PW-1:0]             dquot;
  logic [LW+1:0]             ltrial;
  logic signed [DW-1:0]      dsel;

  psr_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .busy_o (dbusy),
    .quot_o (dquot)
  );

  assign pready = 1'b1;
  assign prdata = (paddr == psr_pkg::AddrStep) ? {1'b0, step_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= psr_pkg::StepReset[psr_pkg::StepW-1:0];
    end else if (psel && penable && pwrite && paddr == psr_pkg::AddrStep) begin
      step_q <= pwdata[psr_pkg::StepW-1:0];
    end
  end

  assign dsel = dl_q[ax_q];
  assign mag  = dsel[DW-1] ? DW'(-dsel) : DW'(dsel);
  assign sq   = mag * mag;
  assign trial = {rem_q[SW-1:0], sh_q[SW-1 -: 2]} - {{(SW-LW){1'b0}}, root_q, 2'b01};
  assign ltrial = {rem_q[LW:0], root_q[LW-1]} - {5'd0, step_q};
  assign jmag = PW'(mag) * PW'(j_q);
  assign point_ready_o = (state_q == psr_pkg::StIdle);
  assign load_out = (state_d == psr_pkg::StOut) && (state_q != psr_pkg::StOut);

  always_comb begin
    state_d     = state_q;
    have_prev_d = have_prev_q;
    acc_d = acc_q;
    root_d = root_q;
    rem_d = rem_q;
    sh_d = sh_q;
    cnt_d = cnt_q;
    ax_d = ax_q;
    n_d = n_q;
    j_d = j_q;
    go_d = 1'b0;
    ov_d = ov_q;
    res_d = res_q;
    dreq.start = 1'b0;
    dreq.numer = jmag;
    dreq.denom = n_q;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      psr_pkg::StIdle: begin
        if (point_valid_i) begin
          if (!have_prev_q) begin
            state_d = is_final_vertex_i ? psr_pkg::StFinal : psr_pkg::StIdle;
            have_prev_d = !is_final_vertex_i;
          end else begin
            state_d = psr_pkg::StSquare;
            acc_d = '0;
            ax_d = 2'd0;
          end
        end
      end
      psr_pkg::StSquare: begin
        acc_d = acc_q + SW'(sq);
        if (ax_q == 2'd2) begin
          state_d = psr_pkg::StSqrt;
          sh_d = acc_q + SW'(sq);
          rem_d = '0;
          root_d = '0;
          cnt_d = 6'(LW - 1);
        end else begin
          ax_d = ax_q + 2'd1;
        end
      end
      psr_pkg::StSqrt: begin
        sh_d = {sh_q[SW-3:0], 2'b00};
        if (!trial[SW+1]) begin
          rem_d = trial;
          root_d = {root_q[LW-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[SW-1:0], sh_q[SW-1 -: 2]};
          root_d = {root_q[LW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          state_d = psr_pkg::StDiv;
          rem_d = '0;
          acc_d = '0;
          cnt_d = 6'(LW - 1);
        end
      end
      psr_pkg::StDiv: begin
        root_d = {root_q[LW-2:0], 1'b0};
        if (!ltrial[LW+1]) begin
          rem_d = (SW+2)'(ltrial);
          acc_d = {acc_q[SW-2:0], 1'b1};
        end else begin
          rem_d = (SW+2)'({rem_q[LW:0], root_q[LW-1]});
          acc_d = {acc_q[SW-2:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          if (step_q == '0 || acc_d >= SW'(psr_pkg::MaxSubdiv)) begin
            n_d = NW'(psr_pkg::MaxSubdiv);
          end else if (acc_d == '0) begin
            n_d = NW'(1);
          end else begin
            n_d = acc_d[NW-1:0];
          end
          j_d = '0;
          ax_d = 2'd0;
          go_d = 1'b1;
          state_d = psr_pkg::StPoint;
        end
      end
      psr_pkg::StPoint: begin
        if (!ov_q) begin
          dreq.start = 1'b1;
          state_d = psr_pkg::StQuot;
          go_d = 1'b1;
        end
      end
      psr_pkg::StQuot: begin
        if (!go_q && !dbusy) begin
          res_d[ax_q] = dsel[DW-1] ? -dquot[31:0] : dquot[31:0];
          if (ax_q == 2'd2) begin
            state_d = psr_pkg::StOut;
            ov_d = 1'b1;
          end else begin
            ax_d = ax_q + 2'd1;
            state_d = psr_pkg::StPoint;
          end
        end
      end
      psr_pkg::StOut: begin
        ax_d = 2'd0;
        if (j_q == n_q) begin
          if (fin_q) begin
            state_d = psr_pkg::StFinal;
          end else begin
            state_d = psr_pkg::StIdle;
          end
        end else begin
          j_d = j_q + NW'(1);
          state_d = psr_pkg::StPoint;
        end
      end
      psr_pkg::StFinal: begin
        if (!ov_q) begin
          ov_d = 1'b1;
          have_prev_d = 1'b0;
          state_d = psr_pkg::StIdle;
        end
      end
      default: state_d = psr_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psr_pkg::StIdle;
      have_prev_q <= 1'b0;
      ov_q <= 1'b0;
      go_q <= 1'b0;
    end else begin
      state_q <= state_d;
      have_prev_q <= have_prev_d;
      ov_q <= ov_d;
      go_q <= go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    root_q <= root_d;
    rem_q <= rem_d;
    sh_q <= sh_d;
    cnt_q <= cnt_d;
    ax_q <= ax_d;
    n_q <= n_d;
    j_q <= j_d;
    res_q <= res_d;
    if (state_q == psr_pkg::StIdle && point_valid_i) begin
      cx_q <= point_x_i;
      cy_q <= point_y_i;
      cz_q <= point_z_i;
      fin_q <= is_final_vertex_i;
      if (!have_prev_q) begin
        px_q <= point_x_i;
        py_q <= point_y_i;
        pz_q <= point_z_i;
      end else begin
        dl_q[0] <= DW'(point_x_i) - DW'(px_q);
        dl_q[1] <= DW'(point_y_i) - DW'(py_q);
        dl_q[2] <= DW'(point_z_i) - DW'(pz_q);
      end
    end
    if (state_q == psr_pkg::StOut && j_q == n_q && !fin_q) begin
      px_q <= cx_q;
      py_q <= cy_q;
      pz_q <= cz_q;
    end
    if (load_out) begin
      ox_q <= px_q + res_d[0];
      oy_q <= py_q + res_d[1];
      oz_q <= pz_q + res_d[2];
      orl_q <= (j_q == n_q) && !fin_q;
      obe_q <= 1'b0;
    end else if (state_q == psr_pkg::StFinal && !ov_q) begin
      ox_q <= cx_q;
      oy_q <= cy_q;
      oz_q <= cz_q;
      orl_q <= 1'b1;
      obe_q <= 1'b1;
    end
  end

  assign out_valid_o    = ov_q;
  assign out_x_o        = ox_q;
  assign out_y_o        = oy_q;
  assign out_z_o        = oz_q;
  assign run_last_o     = orl_q;
  assign boundary_end_o = obe_q;

endmodule
